FILE: rtl/bba_pkg.sv
// shared constants, types and helpers of the buddy block allocator
package bba_pkg;

   localparam int MAX_ORDER = 10;
   localparam int ORD_W     = 4;
   localparam int ADDR_W    = 10;
   localparam int SIZE_W    = 11;
   localparam int MASK_W    = MAX_ORDER + 1;
   localparam int NODE_W    = 11;
   localparam int NODES     = 2047;
   localparam int UNITS     = 1024;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_BADFREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT,
      S_DESC,
      S_SPLIT,
      S_ASC,
      S_FREE_RD,
      S_MERGE,
      S_RESP
   } fsm_state_type;

   // heap index of tree node (order, unit address)
   function automatic logic [NODE_W-1:0] node_idx(input logic [ORD_W-1:0] ord,
                                                  input logic [ADDR_W-1:0] addr);
      logic [ORD_W-1:0] sh;
      sh = ORD_W'(MAX_ORDER) - ord;
      return ((NODE_W'(1) << sh) - NODE_W'(1)) + NODE_W'(addr >> ord);
   endfunction

   // bits below n set
   function automatic logic [MASK_W-1:0] low_mask(input logic [ORD_W-1:0] n);
      return (MASK_W'(1) << n) - MASK_W'(1);
   endfunction

   // smallest order whose block holds size units
   function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] s;
      logic [ORD_W-1:0]  r;
      s = size - SIZE_W'(1);
      r = '0;
      if (size > SIZE_W'(1)) begin
         for (int i = 0; i < SIZE_W; i++) begin
            if (s[i]) r = ORD_W'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/buddy_block_allocator.sv
// buddy block allocator top level: control sequencer, tree memory and block memory
// allocation reads the root, descends to the found order, splits down to the wanted order
//   and updates the parents up to the root; a free reads the block mark, merges upward
// one item in flight: a new request is taken only in the idle state, once the previous
//   response has been handed on; the walk makes one tree memory access per level
// reset and any top_order write run a sweep over all 1024 block memory entries,
//   requests are held off until it ends; configuration writes are always taken
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_size[10:0], block_addr[20:11], zero pad
   input  logic        req_tuser,   // op: 0 allocate, 1 free
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], granted_addr[11:2], granted_order[15:12]
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // top_order
);

   // tree memory: per node, the set of orders with a free block in its subtree;
   // entries below a free node or an allocated block are don't-care
   logic [MASK_W-1:0] mask_mem [NODES];
   logic [MASK_W-1:0] m_rd_ff;
   logic [NODE_W-1:0] m_ra, m_wa;
   logic [MASK_W-1:0] m_wd;
   logic              m_we;

   // block memory: allocated mark and recorded order per unit address
   logic [ORD_W:0]    alloc_mem [UNITS];
   logic [ORD_W:0]    a_rd_ff;
   logic [ADDR_W-1:0] a_ra, a_wa;
   logic [ORD_W:0]    a_wd;
   logic              a_we;

   fsm_state_type     state_ff, state_in;
   logic [ORD_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ORD_W-1:0]  want_ff, want_in;
   logic [ORD_W-1:0]  tgt_ff, tgt_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [MASK_W-1:0] cur_ff, cur_in;
   logic              ph_ff, ph_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ORD_W-1:0]  res_order_ff, res_order_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   // request decode
   logic              req_acc;
   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] req_addr;
   logic [ORD_W-1:0]  want_c;
   logic              oversize;
   logic              out_of_pool;
   // root search
   logic [MASK_W-1:0] hit_mask;
   logic [ORD_W-1:0]  hit_ord;
   // walk helpers
   logic [ADDR_W-1:0] ord_bit;
   logic [ADDR_W-1:0] desc_addr;
   logic [ORD_W-1:0]  ord_up;
   logic [ADDR_W-1:0] up_addr;
   logic [ADDR_W-1:0] up_bit;
   logic [MASK_W-1:0] par_mask;
   logic [MASK_W-1:0] path_mask;
   logic              buddy_free;
   logic [ORD_W-1:0]  blk_ord;
   logic              blk_mark;
   logic              rsp_free;
   logic              clr_last;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_acc     = req_tvalid & req_tready;
   assign req_size    = req_tdata[10:0];
   assign req_addr    = req_tdata[20:11];
   assign want_c      = size_order(req_size);
   assign oversize    = (want_c > top_ff);
   assign out_of_pool = (({1'b0, req_addr} >> top_ff) != 11'd0);

   assign hit_mask = m_rd_ff & ~low_mask(want_ff);
   always_comb begin
      hit_ord = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (hit_mask[i]) hit_ord = ORD_W'(i);
      end
   end

   assign ord_bit    = ADDR_W'(1) << ord_ff;
   // left child holds a block of the target order, else take the right one
   assign desc_addr  = m_rd_ff[tgt_ff] ? addr_ff : (addr_ff | ord_bit);
   assign ord_up     = ord_ff + ORD_W'(1);
   assign up_addr    = addr_ff & ~ord_bit;
   assign up_bit     = ADDR_W'(1) << ord_up;
   assign par_mask   = cur_ff | m_rd_ff;
   assign path_mask  = low_mask(ord_ff) & ~low_mask(want_ff);
   assign buddy_free = m_rd_ff[ord_ff];
   assign blk_mark   = a_rd_ff[ORD_W];
   assign blk_ord    = a_rd_ff[ORD_W-1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign clr_last   = (clr_ff == {ADDR_W{1'b1}});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser) state_in = out_of_pool ? S_RESP : S_FREE_RD;
               else           state_in = oversize ? S_RESP : S_ROOT;
            end
         end
         S_ROOT: begin
            if (hit_mask == '0)      state_in = S_RESP;
            else if (hit_ord == top_ff) state_in = S_SPLIT;
            else                     state_in = S_DESC;
         end
         S_DESC: begin
            if (ord_ff == tgt_ff) state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (!ph_ff && ord_ff == tgt_ff) state_in = (tgt_ff == top_ff) ? S_RESP : S_ASC;
         end
         S_ASC: begin
            if (ord_up == top_ff) state_in = S_RESP;
         end
         S_FREE_RD: begin
            if (!blk_mark || blk_ord >= top_ff) state_in = S_RESP;
            else                                state_in = S_MERGE;
         end
         S_MERGE: begin
            if (!buddy_free)          state_in = S_ASC;
            else if (ord_up == top_ff) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
      if (csr_wr_en) state_in = S_CLEAR;
   end

   // datapath and memory controls
   always_comb begin
      top_in        = top_ff;
      clr_in        = clr_ff;
      want_in       = want_ff;
      tgt_in        = tgt_ff;
      ord_in        = ord_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      ph_in         = ph_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_order_in  = res_order_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      m_ra          = node_idx(ord_ff, addr_ff ^ ord_bit);
      m_we          = 1'b0;
      m_wa          = node_idx(ord_ff, addr_ff);
      m_wd          = '0;
      a_ra          = req_addr;
      a_we          = 1'b0;
      a_wa          = addr_ff;
      a_wd          = '0;
      case (state_ff)
         S_CLEAR: begin
            a_we   = 1'b1;
            a_wa   = clr_ff;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '0) begin
               m_we = 1'b1;
               m_wa = node_idx(top_ff, '0);
               m_wd = MASK_W'(1) << top_ff;
            end
         end
         S_IDLE: begin
            m_ra = node_idx(top_ff, '0);
            if (req_acc) begin
               want_in       = want_c;
               addr_in       = req_tuser ? req_addr : '0;
               res_status_in = STAT_OK;
               res_addr_in   = '0;
               res_order_in  = '0;
               if (req_tuser && out_of_pool) res_status_in = STAT_BADFREE;
               if (!req_tuser && oversize)   res_status_in = STAT_NOSPACE;
            end
         end
         S_ROOT: begin
            tgt_in  = hit_ord;
            addr_in = '0;
            ph_in   = 1'b0;
            // left child of the root; a one-unit pool has none
            m_ra    = node_idx((top_ff == '0) ? '0 : top_ff - ORD_W'(1), '0);
            if (hit_mask == '0)         res_status_in = STAT_NOSPACE;
            else if (hit_ord == top_ff) ord_in = want_ff;
            else                        ord_in = top_ff - ORD_W'(1);
         end
         S_DESC: begin
            addr_in = desc_addr;
            m_ra    = node_idx(ord_ff - ORD_W'(1), desc_addr);
            if (ord_ff == tgt_ff) ord_in = want_ff;
            else                  ord_in = ord_ff - ORD_W'(1);
         end
         S_SPLIT: begin
            m_we = 1'b1;
            if (!ph_ff) begin
               // path node keeps the free upper halves below it
               m_wd = path_mask;
               if (ord_ff == want_ff) begin
                  a_we         = 1'b1;
                  a_wd         = {1'b1, want_ff};
                  res_addr_in  = addr_ff;
                  res_order_in = want_ff;
               end
               if (ord_ff == tgt_ff) cur_in = path_mask;
               else                  ph_in  = 1'b1;
            end else begin
               // upper half of the split becomes free at this order
               m_wa   = node_idx(ord_ff, addr_ff | ord_bit);
               m_wd   = MASK_W'(1) << ord_ff;
               ord_in = ord_up;
               ph_in  = 1'b0;
            end
         end
         S_ASC: begin
            m_we    = 1'b1;
            m_wa    = node_idx(ord_up, up_addr);
            m_wd    = par_mask;
            ord_in  = ord_up;
            addr_in = up_addr;
            cur_in  = par_mask;
            m_ra    = node_idx(ord_up, up_addr ^ up_bit);
         end
         S_FREE_RD: begin
            if (blk_mark) begin
               a_we         = 1'b1;
               res_order_in = blk_ord;
               ord_in       = blk_ord;
               m_ra         = node_idx(blk_ord, addr_ff ^ (ADDR_W'(1) << blk_ord));
               if (blk_ord >= top_ff) begin
                  m_we = 1'b1;
                  m_wa = node_idx(blk_ord, addr_ff);
                  m_wd = MASK_W'(1) << blk_ord;
               end
            end else begin
               res_status_in = STAT_BADFREE;
            end
         end
         S_MERGE: begin
            if (buddy_free) begin
               ord_in  = ord_up;
               addr_in = up_addr;
               m_ra    = node_idx(ord_up, up_addr ^ up_bit);
               if (ord_up == top_ff) begin
                  m_we = 1'b1;
                  m_wa = node_idx(ord_up, up_addr);
                  m_wd = MASK_W'(1) << ord_up;
               end
            end else begin
               // buddy busy: mark merged block free, reread buddy for the walk up
               m_we   = 1'b1;
               m_wd   = MASK_W'(1) << ord_ff;
               cur_in = MASK_W'(1) << ord_ff;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_order_ff, res_addr_ff, res_status_ff};
            end
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         top_in = (csr_wr_data > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : csr_wr_data;
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         top_ff       <= ORD_W'(MAX_ORDER);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff       <= want_in;
      tgt_ff        <= tgt_in;
      ord_ff        <= ord_in;
      addr_ff       <= addr_in;
      cur_ff        <= cur_in;
      ph_ff         <= ph_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_order_ff  <= res_order_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // tree memory
   always_ff @(posedge clock) begin
      if (m_we) mask_mem[m_wa] <= m_wd;
      m_rd_ff <= mask_mem[m_ra];
   end

   // block memory
   always_ff @(posedge clock) begin
      if (a_we) alloc_mem[a_wa] <= a_wd;
      a_rd_ff <= alloc_mem[a_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // failed beats carry zero address and order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] != STAT_OK) |->
         (rsp_data_ff[15:2] == 14'd0))
      else $error("failed response carries nonzero payload");

   // a granted block is aligned to its order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == STAT_OK) |->
         ((rsp_data_ff[11:2] & ((ADDR_W'(1) << rsp_data_ff[15:12]) - ADDR_W'(1))) == '0))
      else $error("granted address not aligned to its order");

   // the sweep runs to its end unless restarted
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !clr_last && !csr_wr_en) |=> (state_ff == S_CLEAR))
      else $error("clear sweep left early");

   // descent stays at or above the target order and below the top
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESC) |-> (ord_ff >= tgt_ff && ord_ff < top_ff))
      else $error("descent order out of range");
`endif

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the buddy block allocator with its own pool predictor
class alloc_scoreboard;
   bit          pool_free[bba_pkg::NODES];
   bit          unit_taken[bba_pkg::UNITS];
   logic [3:0]  unit_order[bba_pkg::UNITS];
   int unsigned pool_order;
   logic [15:0] pending_rsp[$];
   int          mismatches;

   function int unsigned tree_slot(int unsigned ord, int unsigned addr);
      tree_slot = ((1 << (bba_pkg::MAX_ORDER - ord)) - 1) + (addr >> ord);
   endfunction

   function void load_pool(logic [3:0] top);
      pool_order = (top > bba_pkg::MAX_ORDER) ? bba_pkg::MAX_ORDER : top;
      foreach (pool_free[i]) pool_free[i] = 0;
      foreach (unit_taken[i]) unit_taken[i] = 0;
      pool_free[tree_slot(pool_order, 0)] = 1;
   endfunction

   // predict the response of one accepted request beat
   function void note_request(bit is_free, logic [10:0] size, logic [9:0] baddr);
      bba_pkg::status_type st;
      int unsigned want, o, a, cnt, buddy;
      bit found;
      logic [9:0] ga;
      logic [3:0] go;
      st = bba_pkg::STAT_OK;
      ga = '0;
      go = '0;
      found = 0;
      a = 0;
      if (!is_free) begin
         want = 0;
         while ((1 << want) < size) want++;
         if (want > pool_order) st = bba_pkg::STAT_NOSPACE;
         else begin
            for (o = want; o <= pool_order && !found; o++) begin
               cnt = 1 << (pool_order - o);
               for (int b = 0; b < cnt && !found; b++)
                  if (pool_free[tree_slot(o, b << o)]) begin
                     a = b << o;
                     found = 1;
                  end
               if (found) break;
            end
            if (!found) st = bba_pkg::STAT_NOSPACE;
            else begin
               pool_free[tree_slot(o, a)] = 0;
               while (o > want) begin
                  o--;
                  pool_free[tree_slot(o, a + (1 << o))] = 1;
               end
               unit_taken[a] = 1;
               unit_order[a] = 4'(want);
               ga = 10'(a);
               go = 4'(want);
            end
         end
      end else begin
         a = baddr;
         if (a >= (1 << pool_order) || !unit_taken[a]) st = bba_pkg::STAT_BADFREE;
         else begin
            o = unit_order[a];
            go = 4'(o);
            unit_taken[a] = 0;
            while (o < pool_order) begin
               buddy = a ^ (1 << o);
               if (!pool_free[tree_slot(o, buddy)]) break;
               pool_free[tree_slot(o, buddy)] = 0;
               a = a & ~(1 << o);
               o++;
            end
            pool_free[tree_slot(o, a)] = 1;
         end
      end
      pending_rsp.push_back({go, ga, st});
   endfunction

   function void check_response(logic [15:0] got);
      logic [15:0] exp;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", got);
         return;
      end
      exp = pending_rsp.pop_front();
      if (got[1:0] !== exp[1:0] || got[11:2] !== exp[11:2] || got[15:12] !== exp[15:12]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: status %0d/%0d addr %0d/%0d order %0d/%0d",
                     exp[1:0], got[1:0], exp[11:2], got[11:2], exp[15:12], got[15:12]);
      end
   endfunction
endclass

module tb_top;
   import bba_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // request_size[10:0], block_addr[20:11], zero pad
   logic        req_tuser = 0;    // op: 0 allocate, 1 free
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;        // status[1:0], granted_addr[11:2], granted_order[15:12]
   logic        csr_wr_en = 0;
   logic [3:0]  csr_wr_data = '0;

   alloc_scoreboard pool_sb;
   bit          sink_hold;        // new response stalls start only when set
   int          rsp_stall = 0;    // cycles left in the current response stall
   logic [9:0]  live_addr[$];     // addresses handed out and not yet freed

   buddy_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, each accepted beat checked
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) pool_sb.check_response(rsp_tdata);
         if (rsp_stall > 0) rsp_stall--;
         else if (sink_hold && $urandom_range(0, 3) == 0) rsp_stall = gap_len();
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // send one request beat and log it when taken; valid stays up after the beat
   // so a follow-on beat can come with no gap, callers drop it before idling
   task automatic send_request(bit is_free, logic [10:0] size, logic [9:0] baddr);
      int n;
      n = gap_len();
      if (n != 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= is_free;
      req_tdata  <= {3'b000, baddr, size};
      do @(posedge clock); while (!req_tready);
      pool_sb.note_request(is_free, size, baddr);
   endtask

   task automatic alloc_req(logic [10:0] size);
      send_request(0, size, 10'($urandom));
   endtask

   task automatic free_req(logic [9:0] baddr);
      send_request(1, 11'($urandom), baddr);
   endtask

   // wait for the pipe to drain, then write the pool order
   task automatic set_pool_order(logic [3:0] top);
      req_tvalid <= 0;
      while (pool_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= top;
      @(posedge clock);
      csr_wr_en <= 0;
      pool_sb.load_pool(top);
      live_addr.delete();
   endtask

   // random traffic: mostly frees of live blocks and small allocations
   task automatic random_phase(int n);
      int r, k;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40 && live_addr.size() != 0) begin
            k = $urandom_range(0, live_addr.size() - 1);
            free_req(live_addr[k]);
            live_addr.delete(k);
         end else if (r < 50) begin
            free_req(10'($urandom));
         end else begin
            k = $urandom_range(0, 99);
            if (k < 70) alloc_req(11'($urandom_range(0, 8)));
            else if (k < 95) alloc_req(11'($urandom_range(0, 128)));
            else alloc_req(11'($urandom));
         end
         // track granted blocks once the prediction is in
         if (pool_sb.pending_rsp.size() != 0) begin
            logic [15:0] last;
            last = pool_sb.pending_rsp[$];
            if (req_tuser == 0 && last[1:0] == STAT_OK) live_addr.push_back(last[11:2]);
         end
      end
   endtask

   initial begin
      pool_sb = new();
      pool_sb.load_pool(4'd10);
      sink_hold = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: extremes of size and address, each error case
      alloc_req(11'd0);           // zero size counts as one unit
      alloc_req(11'd1);
      alloc_req(11'd1024);        // whole pool while partly used: no space
      free_req(10'd0);
      free_req(10'd0);            // double free
      free_req(10'd1023);         // never allocated
      alloc_req(11'd1024);        // whole pool while unit 1 is still taken: no space
      alloc_req(11'd1);           // granted at the freed unit 0
      free_req(10'd0);
      alloc_req(11'd2047);        // too large
      alloc_req(11'd3);
      alloc_req(11'd513);
      alloc_req(11'd5);
      free_req(10'd4);
      free_req(10'd0);
      set_pool_order(4'd0);
      alloc_req(11'd2);           // above a one-unit pool
      alloc_req(11'd1);
      free_req(10'd1);            // outside the pool
      free_req(10'd0);
      set_pool_order(4'd15);      // saturates to the largest order
      alloc_req(11'd1024);
      free_req(10'd0);

      set_pool_order(4'd3);
      random_phase(150);
      set_pool_order(4'd6);
      random_phase(250);
      sink_hold = 0;
      random_phase(100);          // no new stalls on the response side
      sink_hold = 1;
      set_pool_order(4'd10);
      random_phase(400);
      set_pool_order(4'd1);
      random_phase(100);

      req_tvalid <= 0;
      while (pool_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (pool_sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
